// File: sv/rsr_pkg.sv
package rsr_pkg;

    localparam int DEFAULT_HEAP_DEPTH = 512;
    localparam int KEY_W              = 32;
    localparam int CAP_W              = 10;
    localparam int CAP_RESET          = 512;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SU,
        ST_SU_C,
        ST_TOP,
        ST_LAST,
        ST_SD_L,
        ST_SD_R,
        ST_SD_C,
        ST_EMIT,
        ST_HP_ADDR,
        ST_HP_RD
    } rsr_state_t;

endpackage

// File: sv/replacement_selection_runs_unit.sv
// a fill push sifts the new key up the heap and gives no result
// a replacement push or drain ends in a sift-down from the root, with
// two memory reads per heap level on the single read port
// a run end adds a heapify pass of about count/2 sift-downs before the next item is taken
// one item at a time; a finished result waits in the output register while the next runs
// reset (aresetn low, synchronous): counts zero, filling on, capacity 512, memory not cleared
module replacement_selection_runs_unit #(
    parameter int HEAP_DEPTH = rsr_pkg::DEFAULT_HEAP_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rsr_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rsr_pkg::KEY_W-1:0]   s_tdata,   // value
    input  logic [0:0]                  s_tuser,   // operation
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rsr_pkg::KEY_W-1:0]   m_tdata,   // sorted_value
    output logic                        m_tlast,   // run_end
    output logic [0:0]                  m_tuser    // done_res
);
    import rsr_pkg::*;

    localparam int IW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int LW = IW + 2;
    localparam int AW = IW + 1;

    // lower half / upper half picked by bank: primary is bank_reg, secondary the other
    logic [KEY_W-1:0] heap_mem [2**AW];
    logic [KEY_W-1:0] mem_rdata_reg;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [KEY_W-1:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= heap_mem[mem_raddr];
        end
    end

    rsr_state_t       state_reg, state_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    sec_reg, sec_next;
    logic             filling_reg, filling_next;
    logic             bank_reg, bank_next;
    logic             op_reg, op_next;
    logic             heap_mode_reg, heap_mode_next;
    logic             done_reg, done_next;
    logic             rv_reg, rv_next;
    logic [IW-1:0]    pos_reg, pos_next;
    logic [IW-1:0]    cidx_reg, cidx_next;
    logic [IW-1:0]    hi_reg, hi_next;
    logic [KEY_W-1:0] val_reg, val_next;
    logic [KEY_W-1:0] in_reg, in_next;
    logic [KEY_W-1:0] child_reg, child_next;
    logic [KEY_W-1:0] top_reg, top_next;

    logic             m_valid_reg, m_valid_next;
    logic [KEY_W-1:0] m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;
    logic             m_user_reg, m_user_next;

    logic [CW-1:0]    eff_cap;
    logic [LW-1:0]    l_w, r_w, nl_w;
    logic [IW-1:0]    parent;
    logic [KEY_W-1:0] best;
    logic [IW-1:0]    best_idx;
    logic [CW-1:0]    cnt_dec;
    logic             sd_done;
    logic             out_free;

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CW'(1);
        end else if (32'(cap_reg) > HEAP_DEPTH) begin
            eff_cap = CW'(HEAP_DEPTH);
        end else begin
            eff_cap = CW'(cap_reg);
        end
    end

    assign l_w      = LW'({pos_reg, 1'b1});
    assign r_w      = l_w + LW'(1);
    assign parent   = (pos_reg - IW'(1)) >> 1;
    assign cnt_dec  = count_reg - CW'(1);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        cap_next       = cfg_we ? cfg_wdata : cap_reg;
        count_next     = count_reg;
        sec_next       = sec_reg;
        filling_next   = filling_reg;
        bank_next      = bank_reg;
        op_next        = op_reg;
        heap_mode_next = heap_mode_reg;
        done_next      = done_reg;
        rv_next        = rv_reg;
        pos_next       = pos_reg;
        cidx_next      = cidx_reg;
        hi_next        = hi_reg;
        val_next       = val_reg;
        in_next        = in_reg;
        child_next     = child_reg;
        top_next       = top_reg;
        m_valid_next   = m_tready ? 1'b0 : m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = val_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        s_tready       = 1'b0;
        sd_done        = 1'b0;
        best           = child_reg;
        best_idx       = cidx_reg;
        nl_w           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next = s_tuser[0];
                    in_next = s_tdata;
                    if (s_tuser[0] == OP_PUSH && filling_reg && count_reg < eff_cap) begin
                        pos_next     = count_reg[IW-1:0];
                        val_next     = s_tdata;
                        count_next   = count_reg + CW'(1);
                        filling_next = !(({1'b0, count_reg} + (CW+1)'(1)) >= {1'b0, eff_cap});
                        state_next   = ST_SU;
                    end else if (s_tuser[0] == OP_DRAIN && count_reg == '0) begin
                        filling_next = 1'b1;
                        top_next     = '0;
                        done_next    = 1'b1;
                        state_next   = ST_EMIT;
                    end else begin
                        filling_next = 1'b0;
                        done_next    = 1'b0;
                        mem_re       = 1'b1;
                        mem_raddr    = {bank_reg, IW'(0)};
                        state_next   = ST_TOP;
                    end
                end
            end
            ST_SU: begin
                if (pos_reg == '0) begin
                    mem_we     = 1'b1;
                    mem_waddr  = {bank_reg, IW'(0)};
                    state_next = ST_IDLE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = {bank_reg, parent};
                    state_next = ST_SU_C;
                end
            end
            ST_SU_C: begin
                mem_we    = 1'b1;
                mem_waddr = {bank_reg, pos_reg};
                if ($signed(val_reg) < $signed(mem_rdata_reg)) begin
                    mem_wdata  = mem_rdata_reg;
                    pos_next   = parent;
                    state_next = ST_SU;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TOP: begin
                top_next       = mem_rdata_reg;
                heap_mode_next = 1'b0;
                if (op_reg == OP_PUSH && !($signed(in_reg) < $signed(mem_rdata_reg))) begin
                    val_next   = in_reg;
                    pos_next   = '0;
                    state_next = ST_SD_L;
                end else begin
                    if (op_reg == OP_PUSH && sec_reg < CW'(HEAP_DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = {!bank_reg, sec_reg[IW-1:0]};
                        mem_wdata = in_reg;
                        sec_next  = sec_reg + CW'(1);
                    end
                    count_next = cnt_dec;
                    if (cnt_dec == '0) begin
                        state_next = ST_EMIT;
                    end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = {bank_reg, cnt_dec[IW-1:0]};
                        state_next = ST_LAST;
                    end
                end
            end
            ST_LAST: begin
                val_next   = mem_rdata_reg;
                pos_next   = '0;
                state_next = ST_SD_L;
            end
            ST_SD_L: begin
                if (l_w < LW'(count_reg)) begin
                    mem_re     = 1'b1;
                    mem_raddr  = {bank_reg, l_w[IW-1:0]};
                    state_next = ST_SD_R;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = {bank_reg, pos_reg};
                    sd_done   = 1'b1;
                end
            end
            ST_SD_R: begin
                child_next = mem_rdata_reg;
                cidx_next  = l_w[IW-1:0];
                rv_next    = r_w < LW'(count_reg);
                if (r_w < LW'(count_reg)) begin
                    mem_re    = 1'b1;
                    mem_raddr = {bank_reg, r_w[IW-1:0]};
                end
                state_next = ST_SD_C;
            end
            ST_SD_C: begin
                if (rv_reg && $signed(mem_rdata_reg) < $signed(child_reg)) begin
                    best     = mem_rdata_reg;
                    best_idx = cidx_reg + IW'(1);
                end
                mem_we    = 1'b1;
                mem_waddr = {bank_reg, pos_reg};
                nl_w      = LW'({best_idx, 1'b1});
                if ($signed(best) < $signed(val_reg)) begin
                    mem_wdata = best;
                    pos_next  = best_idx;
                    if (nl_w < LW'(count_reg)) begin
                        mem_re     = 1'b1;
                        mem_raddr  = {bank_reg, nl_w[IW-1:0]};
                        state_next = ST_SD_R;
                    end else begin
                        state_next = ST_SD_L;
                    end
                end else begin
                    sd_done = 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = top_reg;
                    m_user_next  = done_reg;
                    m_last_next  = !done_reg && count_reg == '0;
                    state_next   = ST_IDLE;
                    if (!done_reg && count_reg == '0) begin
                        // run closed: secondary becomes primary and, if not empty, gets heapified
                        bank_next      = !bank_reg;
                        count_next     = sec_reg;
                        sec_next       = '0;
                        hi_next        = IW'(sec_reg >> 1);
                        heap_mode_next = 1'b1;
                        if (sec_reg == '0) begin
                            filling_next = 1'b1;
                        end else begin
                            state_next = ST_HP_ADDR;
                        end
                    end
                end
            end
            ST_HP_ADDR: begin
                mem_re     = 1'b1;
                mem_raddr  = {bank_reg, hi_reg};
                state_next = ST_HP_RD;
            end
            ST_HP_RD: begin
                val_next   = mem_rdata_reg;
                pos_next   = hi_reg;
                state_next = ST_SD_L;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (sd_done) begin
            if (!heap_mode_reg) begin
                state_next = ST_EMIT;
            end else if (hi_reg == '0) begin
                state_next = ST_IDLE;
            end else begin
                hi_next    = hi_reg - IW'(1);
                state_next = ST_HP_ADDR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_W'(CAP_RESET);
            count_reg     <= '0;
            sec_reg       <= '0;
            filling_reg   <= 1'b1;
            bank_reg      <= 1'b0;
            heap_mode_reg <= 1'b0;
            done_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            sec_reg       <= sec_next;
            filling_reg   <= filling_next;
            bank_reg      <= bank_next;
            heap_mode_reg <= heap_mode_next;
            done_reg      <= done_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        rv_reg     <= rv_next;
        pos_reg    <= pos_next;
        cidx_reg   <= cidx_next;
        hi_reg     <= hi_next;
        val_reg    <= val_next;
        in_reg     <= in_next;
        child_reg  <= child_next;
        top_reg    <= top_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_user_reg;

`ifndef NO_ASSERTIONS
    a_total_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(count_reg) + 32'(sec_reg)) <= HEAP_DEPTH)
        else $error("primary plus secondary exceeds heap depth");

    a_idle_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !filling_reg) |-> count_reg != '0)
        else $error("idle out of fill with an empty primary heap");

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (!m_tlast && m_tdata == '0))
        else $error("done result carries data or run end");

    a_done_refill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && done_reg) |-> (filling_reg && count_reg == '0))
        else $error("done result without empty stores");
`endif

endmodule

// File: sim/replacement_selection_runs_checker.sv
`timescale 1ns / 100ps

module replacement_selection_runs_checker #(
    parameter int HEAP_DEPTH = rsr_pkg::DEFAULT_HEAP_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rsr_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [rsr_pkg::KEY_W-1:0]   s_tdata,
    input  logic [0:0]                  s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [rsr_pkg::KEY_W-1:0]   m_tdata,
    input  logic                        m_tlast,
    input  logic [0:0]                  m_tuser,
    output int                          fail_count,
    output int                          awaited,
    output int                          held_keys
);
    import rsr_pkg::*;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic             run_end;
        logic             done;
    } run_out_t;

    run_out_t             run_out_q[$];
    logic [KEY_W-1:0]     heap_mem[HEAP_DEPTH];
    logic [KEY_W-1:0]     spill_mem[HEAP_DEPTH];
    int                   heap_cnt;
    int                   spill_cnt;
    bit                   filling;
    logic [CAP_W-1:0]     cap_reg;

    function automatic bit key_lt(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic int fill_limit();
        if (cap_reg == 0) return 1;
        if (cap_reg > HEAP_DEPTH) return HEAP_DEPTH;
        return cap_reg;
    endfunction

    function automatic void sink(int pos);
        int l, r, m;
        logic [KEY_W-1:0] t;
        while (pos < heap_cnt) begin
            l = 2 * pos + 1;
            r = l + 1;
            m = pos;
            if (l < heap_cnt && key_lt(heap_mem[l], heap_mem[m])) m = l;
            if (r < heap_cnt && key_lt(heap_mem[r], heap_mem[m])) m = r;
            if (m == pos) break;
            t = heap_mem[pos];
            heap_mem[pos] = heap_mem[m];
            heap_mem[m] = t;
            pos = m;
        end
    endfunction

    function automatic void rise(int pos);
        int p;
        logic [KEY_W-1:0] t;
        while (pos > 0) begin
            p = (pos - 1) / 2;
            if (!key_lt(heap_mem[pos], heap_mem[p])) break;
            t = heap_mem[pos];
            heap_mem[pos] = heap_mem[p];
            heap_mem[p] = t;
            pos = p;
        end
    endfunction

    // the parked keys become the next run
    function automatic void start_next_run();
        heap_cnt = spill_cnt;
        for (int i = 0; i < heap_cnt; i++) heap_mem[i] = spill_mem[i];
        spill_cnt = 0;
        for (int i = heap_cnt / 2; i >= 0; i--) sink(i);
        if (heap_cnt == 0) filling = 1;
    endfunction

    function automatic void predict_item(logic op, logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] top;
        run_out_t r;
        if (op == OP_PUSH) begin
            if (filling && heap_cnt < fill_limit() && heap_cnt < HEAP_DEPTH) begin
                heap_mem[heap_cnt] = v;
                heap_cnt++;
                rise(heap_cnt - 1);
                if (heap_cnt >= fill_limit()) filling = 0;
                return;
            end
            filling = 0;
            top = heap_mem[0];
            if (!key_lt(v, top)) begin
                heap_mem[0] = v;
            end else begin
                // key too small for this run: park it for the next one
                if (spill_cnt < HEAP_DEPTH) begin
                    spill_mem[spill_cnt] = v;
                    spill_cnt++;
                end
                heap_cnt--;
                heap_mem[0] = heap_mem[heap_cnt];
            end
            sink(0);
        end else begin
            if (heap_cnt == 0) begin
                filling = 1;
                r = '{key: '0, run_end: 1'b0, done: 1'b1};
                run_out_q.push_back(r);
                return;
            end
            filling = 0;
            top = heap_mem[0];
            heap_cnt--;
            heap_mem[0] = heap_mem[heap_cnt];
            sink(0);
        end
        r = '{key: top, run_end: (heap_cnt == 0), done: 1'b0};
        run_out_q.push_back(r);
        if (heap_cnt == 0) start_next_run();
    endfunction

    always @(posedge aclk) begin
        run_out_t e;
        if (!aresetn) begin
            heap_cnt  = 0;
            spill_cnt = 0;
            filling   = 1;
            cap_reg   = CAP_W'(CAP_RESET);
            run_out_q.delete();
        end else begin
            if (cfg_we) cap_reg = cfg_wdata;
            if (m_tvalid && m_tready) begin
                if (run_out_q.size() == 0) begin
                    $error("result transfer with nothing expected: sorted_value %0d",
                           $signed(m_tdata));
                    fail_count++;
                end else begin
                    e = run_out_q.pop_front();
                    if (m_tdata !== e.key) begin
                        $error("sorted_value expected %0d actual %0d",
                               $signed(e.key), $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tlast !== e.run_end) begin
                        $error("run_end expected %0b actual %0b", e.run_end, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser[0] !== e.done) begin
                        $error("done_res expected %0b actual %0b", e.done, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_item(s_tuser[0], s_tdata);
        end
        awaited   = run_out_q.size();
        held_keys = heap_cnt + spill_cnt;
    end

endmodule

// File: sim/replacement_selection_runs_unit_test.sv
`timescale 1ns / 100ps

module replacement_selection_runs_unit_test;
    import rsr_pkg::*;

    localparam int IDLE_LIMIT = 100000;
    // worst heapify after a run end is about 256 sift-downs
    localparam int SETTLE     = 7000;
    localparam int LONG_HOLD  = 400;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_we = 0;
    logic [CAP_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid = 0;
    logic               s_tready;
    logic [KEY_W-1:0]   s_tdata = '0;
    logic [0:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 0;
    logic [KEY_W-1:0]   m_tdata;
    logic               m_tlast;
    logic [0:0]         m_tuser;

    int  fail_count, awaited, held_keys;
    logic s_took = 0;
    int  burst_left = 0;
    int  gap_max = 3;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  stretch_left = 0;
    int  rx_mode = 0;
    int  rx_cyc = 0;
    int  idle_cycles = 0;

    always #5 aclk = ~aclk;

    replacement_selection_runs_unit dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    replacement_selection_runs_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser), .fail_count(fail_count), .awaited(awaited),
        .held_keys(held_keys)
    );

    always @(posedge aclk) s_took <= s_tvalid & s_tready;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("replacement_selection_runs_unit_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: stretches of always-ready, random and periodic stalls, plus a long hold on request
    always @(negedge aclk) begin
        rx_cyc++;
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(20, 200);
                rx_mode = $urandom_range(0, 2);
            end
            stretch_left--;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 6);
                default: m_tready <= (rx_cyc % 4 != 0);
            endcase
        end
    end

    task automatic send_item(logic op, logic [KEY_W-1:0] v);
        int gap;
        s_tuser  <= op;
        s_tdata  <= v;
        s_tvalid <= 1'b1;
        do @(negedge aclk); while (!s_took);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, gap_max);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2: return $urandom_range(0, 40) - 20;
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (awaited != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_cap(logic [CAP_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // pop every stored key, then one more drain that reports done
    task automatic drain_out();
        while (held_keys > 0) send_item(OP_DRAIN, $urandom);
        send_item(OP_DRAIN, $urandom);
    endtask

    initial begin
        int caps[8] = '{1, 0, 1023, 5, 2, 17, 64, 3};
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_cap(4);
        send_item(OP_DRAIN, 32'hFFFF_FFFF);
        send_item(OP_PUSH, 32'h8000_0000);
        send_item(OP_PUSH, 32'h7FFF_FFFF);
        send_item(OP_PUSH, 32'h0000_0000);
        send_item(OP_PUSH, 32'hFFFF_FFFF);
        send_item(OP_PUSH, 32'd5);
        send_item(OP_PUSH, 32'h8000_0000);
        send_item(OP_PUSH, 32'hFFFF_FFFF);
        send_item(OP_PUSH, 32'hFFFF_FFFF);
        drain_out();
        quiesce();

        // lower the capacity below the fill level mid-fill
        set_cap(10);
        repeat (6) send_item(OP_PUSH, pick_key());
        quiesce();
        set_cap(3);
        repeat (5) send_item(OP_PUSH, pick_key());
        drain_out();
        quiesce();

        foreach (caps[i]) begin
            set_cap(CAP_W'(caps[i]));
            gap_max = $urandom_range(1, 8);
            if (i == 3) begin
                hold_reqs++;
                burst_left = 1000;
            end
            repeat (55) send_item($urandom_range(0, 9) == 0 ? OP_DRAIN : OP_PUSH, pick_key());
            burst_left = 0;
            if (i % 2 == 1) drain_out();
            quiesce();
        end

        set_cap(512);
        repeat (40) send_item(OP_PUSH, pick_key());
        drain_out();
        quiesce();

        if (fail_count == 0 && awaited == 0) begin
            $display("replacement_selection_runs_unit_test: PASS");
        end else begin
            $display("replacement_selection_runs_unit_test: FAIL");
        end
        $finish;
    end

endmodule

// File: replacement_selection_runs_unit.f
sv/rsr_pkg.sv
sv/replacement_selection_runs_unit.sv
sim/replacement_selection_runs_checker.sv
sim/replacement_selection_runs_unit_test.sv
